>>> sv/spd_pkg.sv
`default_nettype none

package spd_pkg;

    localparam int unsigned ByteWidth   = 8;
    localparam int unsigned LenWidth    = 32;
    localparam int unsigned HdrPosWidth = 3;

    localparam logic [ByteWidth-1:0] ID_STDOUT = 8'd1;
    localparam logic [ByteWidth-1:0] ID_STDERR = 8'd2;
    localparam logic [ByteWidth-1:0] ID_EXIT   = 8'd3;

    localparam logic [HdrPosWidth-1:0] HDR_ID      = 3'd0;
    localparam logic [HdrPosWidth-1:0] HDR_LEN_LO  = 3'd1;
    localparam logic [HdrPosWidth-1:0] HDR_LEN_HI  = 3'd4;
    localparam logic [HdrPosWidth-1:0] HEADER_BYTES = 3'd5;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    localparam logic RES_PAYLOAD = 1'b0;
    localparam logic RES_SUMMARY = 1'b1;

    localparam logic CH_STDOUT = 1'b0;
    localparam logic CH_STDERR = 1'b1;

    typedef logic [ByteWidth-1:0] byte_t;
    typedef logic [LenWidth-1:0]  len_t;

endpackage

`default_nettype wire

>>> sv/shell_packet_deframer_top.sv
// A word that yields a result shows it on the output in the cycle after acceptance.
// Throughput: one input word per cycle; the only stall is a held result that is not taken.
// Header, length and payload tracking update on each accepted word.
// Reset (rst_n, asynchronous, active low) clears the header position, length,
// packet id, pending exit byte, exit code and the output valid flag.
`default_nettype none

module shell_packet_deframer_top
    import spd_pkg::*;
(
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    input  wire                  kind,
    input  wire  [ByteWidth-1:0] stream_byte,
    output logic                 out_valid,
    input  wire                  out_ready,
    output logic                 result_kind,
    output logic [ByteWidth-1:0] payload_byte,
    output logic                 channel,
    output logic                 packet_end,
    output logic [ByteWidth-1:0] exit_status,
    output logic                 success,
    output logic                 truncated
);

    logic [HdrPosWidth-1:0] hdr_pos_reg, hdr_pos_next;
    byte_t                  packet_id_reg, packet_id_next;
    len_t                   bytes_left_reg, bytes_left_next;
    logic                   in_payload_reg, in_payload_next;
    byte_t                  pending_exit_reg, pending_exit_next;
    logic                   pending_valid_reg, pending_valid_next;
    byte_t                  ret_code_reg, ret_code_next;

    logic                   out_valid_reg, out_valid_next;
    logic                   res_kind_reg, res_kind_next;
    byte_t                  res_byte_reg, res_byte_next;
    logic                   res_channel_reg, res_channel_next;
    logic                   res_end_reg, res_end_next;
    byte_t                  res_exit_reg, res_exit_next;
    logic                   res_success_reg, res_success_next;
    logic                   res_trunc_reg, res_trunc_next;

    logic                   accept;
    logic                   emit;
    logic                   last;
    len_t                   len_merged;
    logic [1:0]             len_sel;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;
    assign last     = (bytes_left_reg == len_t'(1));
    assign len_sel  = 2'(hdr_pos_reg - HDR_LEN_LO);

    always_comb
    begin
        len_merged = bytes_left_reg;
        unique case (len_sel)
            2'd0: len_merged[7:0]   = stream_byte;
            2'd1: len_merged[15:8]  = stream_byte;
            2'd2: len_merged[23:16] = stream_byte;
            2'd3: len_merged[31:24] = stream_byte;
            default: len_merged = bytes_left_reg;
        endcase
    end

    always_comb
    begin
        hdr_pos_next       = hdr_pos_reg;
        packet_id_next     = packet_id_reg;
        bytes_left_next    = bytes_left_reg;
        in_payload_next    = in_payload_reg;
        pending_exit_next  = pending_exit_reg;
        pending_valid_next = pending_valid_reg;
        ret_code_next      = ret_code_reg;

        emit             = 1'b0;
        res_kind_next    = RES_PAYLOAD;
        res_byte_next    = '0;
        res_channel_next = CH_STDOUT;
        res_end_next     = 1'b0;
        res_exit_next    = '0;
        res_success_next = 1'b0;
        res_trunc_next   = 1'b0;

        if (accept)
        begin
            priority if (kind == KIND_EOS)
            begin
                emit               = 1'b1;
                res_kind_next      = RES_SUMMARY;
                res_exit_next      = ret_code_reg;
                res_success_next   = (ret_code_reg == '0);
                res_trunc_next     = in_payload_reg;
                hdr_pos_next       = HDR_ID;
                packet_id_next     = '0;
                bytes_left_next    = '0;
                in_payload_next    = 1'b0;
                pending_exit_next  = '0;
                pending_valid_next = 1'b0;
                ret_code_next      = '0;
            end
            else if (in_payload_reg)
            begin
                bytes_left_next = bytes_left_reg - len_t'(1);
                if (packet_id_reg == ID_EXIT && !pending_valid_reg)
                begin
                    pending_exit_next  = stream_byte;
                    pending_valid_next = 1'b1;
                end
                if (packet_id_reg == ID_STDOUT || packet_id_reg == ID_STDERR)
                begin
                    emit             = 1'b1;
                    res_byte_next    = stream_byte;
                    res_channel_next = (packet_id_reg == ID_STDERR) ? CH_STDERR : CH_STDOUT;
                    res_end_next     = last;
                end
                if (last)
                begin
                    if (packet_id_reg == ID_EXIT && pending_valid_next)
                    begin
                        ret_code_next = pending_exit_next;
                    end
                    pending_valid_next = 1'b0;
                    in_payload_next    = 1'b0;
                    hdr_pos_next       = HDR_ID;
                    bytes_left_next    = '0;
                end
            end
            else if (hdr_pos_reg == HDR_ID || hdr_pos_reg >= HEADER_BYTES)
            begin
                packet_id_next     = stream_byte;
                bytes_left_next    = '0;
                pending_valid_next = 1'b0;
                hdr_pos_next       = HDR_LEN_LO;
            end
            else
            begin
                bytes_left_next = len_merged;
                hdr_pos_next    = hdr_pos_reg + HDR_LEN_LO;
                if (hdr_pos_reg == HDR_LEN_HI)
                begin
                    hdr_pos_next = HDR_ID;
                    if (len_merged == '0)
                    begin
                        pending_valid_next = 1'b0;
                        in_payload_next    = 1'b0;
                        bytes_left_next    = '0;
                    end
                    else
                    begin
                        in_payload_next = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_pos_reg       <= HDR_ID;
            packet_id_reg     <= '0;
            bytes_left_reg    <= '0;
            in_payload_reg    <= 1'b0;
            pending_exit_reg  <= '0;
            pending_valid_reg <= 1'b0;
            ret_code_reg      <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            hdr_pos_reg       <= hdr_pos_next;
            packet_id_reg     <= packet_id_next;
            bytes_left_reg    <= bytes_left_next;
            in_payload_reg    <= in_payload_next;
            pending_exit_reg  <= pending_exit_next;
            pending_valid_reg <= pending_valid_next;
            ret_code_reg      <= ret_code_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // hold the result until taken
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_kind_reg    <= res_kind_next;
            res_byte_reg    <= res_byte_next;
            res_channel_reg <= res_channel_next;
            res_end_reg     <= res_end_next;
            res_exit_reg    <= res_exit_next;
            res_success_reg <= res_success_next;
            res_trunc_reg   <= res_trunc_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_kind  = res_kind_reg;
    assign payload_byte = res_byte_reg;
    assign channel      = res_channel_reg;
    assign packet_end   = res_end_reg;
    assign exit_status  = res_exit_reg;
    assign success      = res_success_reg;
    assign truncated    = res_trunc_reg;

endmodule

`default_nettype wire

>>> sv/spd_checker.sv
`default_nettype none

module spd_checker
    import spd_pkg::*;
(
    input wire                 clk,
    input wire                 rst_n,
    input wire                 in_ready,
    input wire                 out_valid,
    input wire                 out_ready,
    input wire                 result_kind,
    input wire [ByteWidth-1:0] payload_byte,
    input wire                 channel,
    input wire                 packet_end,
    input wire [ByteWidth-1:0] exit_status,
    input wire                 success,
    input wire                 truncated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind)
            && $stable(payload_byte) && $stable(exit_status) && $stable(truncated))
        else $error("result changed while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_summary_success: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RES_SUMMARY |->
            success == (exit_status == '0) && payload_byte == '0
            && channel == CH_STDOUT && !packet_end)
        else $error("summary word inconsistent");

    a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_kind == RES_PAYLOAD |->
            exit_status == '0 && !success && !truncated)
        else $error("payload word carries summary fields");

endmodule

bind shell_packet_deframer_top spd_checker u_spd_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .result_kind  (result_kind),
    .payload_byte (payload_byte),
    .channel      (channel),
    .packet_end   (packet_end),
    .exit_status  (exit_status),
    .success      (success),
    .truncated    (truncated)
);

`default_nettype wire
